// ===== rtl/smpm_pkg.sv =====
// ============================================================================
// smpm_pkg
// Shared constants and types for the stereo matrix with peak meter: default
// sample width, configuration register map and the decoded control struct.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package smpm_pkg;

    // Default sample width in bits (two's complement).
    localparam int SAMPLE_BITS_DEF = 24;

    // Configuration port geometry: eight 32-bit registers at 4-byte spacing.
    localparam int PADDR_BITS  = 5;
    localparam int REG_IDX_LSB = 2;
    localparam int PDATA_BITS  = 32;

    typedef logic [PADDR_BITS-REG_IDX_LSB-1:0] reg_idx_t;

    // Register indexes.
    localparam reg_idx_t REG_BYPASS        = 3'd0;
    localparam reg_idx_t REG_STEREO_MODE   = 3'd1;
    localparam reg_idx_t REG_INVERT_MONO   = 3'd2;
    localparam reg_idx_t REG_INVERT_MID    = 3'd3;
    localparam reg_idx_t REG_INVERT_SIDE   = 3'd4;
    localparam reg_idx_t REG_MS_DECODE     = 3'd5;
    localparam reg_idx_t REG_SWAP_CHANNELS = 3'd6;
    localparam reg_idx_t REG_MONO_SUM      = 3'd7;

    // Control bits handed from the register file to the matrix.
    typedef struct packed {
        logic bypass;
        logic stereo_mode;
        logic invert_mono;
        logic invert_mid;
        logic invert_side;
        logic ms_decode;
        logic swap_channels;
        logic mono_sum;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        bypass:        1'b0,
        stereo_mode:   1'b1,
        invert_mono:   1'b0,
        invert_mid:    1'b0,
        invert_side:   1'b0,
        ms_decode:     1'b0,
        swap_channels: 1'b0,
        mono_sum:      1'b0
    };

endpackage

`default_nettype wire

// ===== rtl/smpm_matrix.sv =====
// ============================================================================
// smpm_matrix
// Combinational sample matrix: bypass, mono inversion, and the stereo chain
// of mid/side inversion, mid/side decode, channel swap and mono sum.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module smpm_matrix
    import smpm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire cfg_t                    cfg,
    input  wire logic [SAMPLE_BITS-1:0]  in0,
    input  wire logic [SAMPLE_BITS-1:0]  in1,
    output logic      [SAMPLE_BITS-1:0]  out0,
    output logic      [SAMPLE_BITS-1:0]  out1
);

    localparam logic [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Negation that maps the most negative sample to the most positive one.
    function automatic logic [SAMPLE_BITS-1:0] sat_neg(input logic [SAMPLE_BITS-1:0] x);
        sat_neg = (x == SMIN) ? SMAX : (~x + 1'b1);
    endfunction

    logic [SAMPLE_BITS-1:0] neg0;
    logic [SAMPLE_BITS-1:0] neg1;
    logic [SAMPLE_BITS-1:0] mid;
    logic [SAMPLE_BITS-1:0] side;
    logic [SAMPLE_BITS:0]   sum_ms;
    logic [SAMPLE_BITS:0]   dif_ms;
    logic [SAMPLE_BITS-1:0] dec_x;
    logic [SAMPLE_BITS-1:0] dec_y;
    logic [SAMPLE_BITS-1:0] swp_x;
    logic [SAMPLE_BITS-1:0] swp_y;
    logic [SAMPLE_BITS:0]   sum_xy;
    logic [SAMPLE_BITS-1:0] st_x;
    logic [SAMPLE_BITS-1:0] st_y;

    assign neg0 = sat_neg(in0);
    assign neg1 = sat_neg(in1);

    // Stereo chain: inversion, optional decode with halving, swap, mono sum.
    always_comb begin
        mid    = cfg.invert_mid  ? neg0 : in0;
        side   = cfg.invert_side ? neg1 : in1;
        sum_ms = {mid[SAMPLE_BITS-1], mid} + {side[SAMPLE_BITS-1], side};
        dif_ms = {mid[SAMPLE_BITS-1], mid} - {side[SAMPLE_BITS-1], side};
        if (cfg.ms_decode) begin
            dec_x = sum_ms[SAMPLE_BITS:1];
            dec_y = dif_ms[SAMPLE_BITS:1];
        end else begin
            dec_x = mid;
            dec_y = side;
        end
        swp_x  = cfg.swap_channels ? dec_y : dec_x;
        swp_y  = cfg.swap_channels ? dec_x : dec_y;
        sum_xy = {swp_x[SAMPLE_BITS-1], swp_x} + {swp_y[SAMPLE_BITS-1], swp_y};
        if (cfg.ms_decode && cfg.mono_sum) begin
            // The exact mono value of a decoded pair is half the mid.
            st_x = {mid[SAMPLE_BITS-1], mid[SAMPLE_BITS-1:1]};
            st_y = st_x;
        end else if (cfg.mono_sum) begin
            st_x = sum_xy[SAMPLE_BITS:1];
            st_y = st_x;
        end else begin
            st_x = swp_x;
            st_y = swp_y;
        end
    end

    // Mode selection; channel 1 is forced to zero in mono mode.
    always_comb begin
        if (!cfg.stereo_mode) begin
            out0 = (!cfg.bypass && cfg.invert_mono) ? neg0 : in0;
            out1 = '0;
        end else if (cfg.bypass) begin
            out0 = in0;
            out1 = in1;
        end else begin
            out0 = st_x;
            out1 = st_y;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/smpm_peak.sv =====
// ============================================================================
// smpm_peak
// Peak meter: holds the largest saturated magnitude seen on input channel 0
// and on output channel 0, with a restart on clear.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module smpm_peak
    import smpm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    load,
    input  wire logic                    clear,
    input  wire logic [SAMPLE_BITS-1:0]  in0,
    input  wire logic [SAMPLE_BITS-1:0]  out0,
    output logic      [SAMPLE_BITS-2:0]  peak_in,
    output logic      [SAMPLE_BITS-2:0]  peak_out
);

    localparam logic [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Absolute value, saturated to the largest positive sample.
    function automatic logic [SAMPLE_BITS-2:0] mag(input logic [SAMPLE_BITS-1:0] x);
        logic [SAMPLE_BITS-1:0] neg;
        neg = ~x + 1'b1;
        if (x == SMIN) begin
            mag = {(SAMPLE_BITS-1){1'b1}};
        end else if (x[SAMPLE_BITS-1]) begin
            mag = neg[SAMPLE_BITS-2:0];
        end else begin
            mag = x[SAMPLE_BITS-2:0];
        end
    endfunction

    logic [SAMPLE_BITS-2:0] pk_in_reg;
    logic [SAMPLE_BITS-2:0] pk_in_next;
    logic [SAMPLE_BITS-2:0] pk_out_reg;
    logic [SAMPLE_BITS-2:0] pk_out_next;
    logic [SAMPLE_BITS-2:0] mag_in;
    logic [SAMPLE_BITS-2:0] mag_out;

    assign mag_in  = mag(in0);
    assign mag_out = mag(out0);

    // Restart from the current sample on clear, otherwise keep the maximum.
    always_comb begin
        pk_in_next  = pk_in_reg;
        pk_out_next = pk_out_reg;
        if (load) begin
            if (clear || (mag_in > pk_in_reg)) begin
                pk_in_next = mag_in;
            end
            if (clear || (mag_out > pk_out_reg)) begin
                pk_out_next = mag_out;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pk_in_reg  <= '0;
            pk_out_reg <= '0;
        end else begin
            pk_in_reg  <= pk_in_next;
            pk_out_reg <= pk_out_next;
        end
    end

    assign peak_in  = pk_in_reg;
    assign peak_out = pk_out_reg;

endmodule

`default_nettype wire

// ===== rtl/stereo_matrix_with_peak_meter.sv =====
// A result passes through a two-stage pipeline: the input register, then the result register.
// Throughput: one item per cycle while m_ready is high or the result register is empty.
// Both peaks are updated as an item moves into the result register, so they travel with it.
// Reset (aresetn low, synchronous): pipeline emptied, both peaks zero, registers at
// their defaults (stereo mode on, all others off). No clearing pass is needed.
// ============================================================================
// stereo_matrix_with_peak_meter
// Mid/side stereo matrix on 24-bit sample pairs with input and output peak
// meters, a two-stage valid/ready pipeline and an APB-style register port.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module stereo_matrix_with_peak_meter
    import smpm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    // Input channel
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [SAMPLE_BITS-1:0]  s_sample_in0,
    input  wire logic [SAMPLE_BITS-1:0]  s_sample_in1,
    input  wire logic                    s_clear_peaks,
    // Result channel
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic      [SAMPLE_BITS-1:0]  m_sample_out0,
    output logic      [SAMPLE_BITS-1:0]  m_sample_out1,
    output logic      [SAMPLE_BITS-2:0]  m_peak_input,
    output logic      [SAMPLE_BITS-2:0]  m_peak_output,
    // Configuration port
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [PADDR_BITS-1:0]   paddr,
    input  wire logic [PDATA_BITS-1:0]   pwdata,
    output logic      [PDATA_BITS-1:0]   prdata,
    output logic                         pready
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t reg_idx;
    logic     wr_en;
    logic     rd_bit;

    logic                   in_valid_reg;
    logic [SAMPLE_BITS-1:0] in0_reg;
    logic [SAMPLE_BITS-1:0] in1_reg;
    logic                   clr_reg;

    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] out0_reg;
    logic [SAMPLE_BITS-1:0] out1_reg;

    logic                   advance;
    logic                   in_xfer;
    logic [SAMPLE_BITS-1:0] mat_out0;
    logic [SAMPLE_BITS-1:0] mat_out1;

    // ------------------------------------------------------------------------
    // Register file.
    // ------------------------------------------------------------------------
    assign reg_idx = paddr[PADDR_BITS-1:REG_IDX_LSB];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Write decode: only bit 0 of the data is kept.
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_BYPASS:        cfg_next.bypass        = pwdata[0];
                REG_STEREO_MODE:   cfg_next.stereo_mode   = pwdata[0];
                REG_INVERT_MONO:   cfg_next.invert_mono   = pwdata[0];
                REG_INVERT_MID:    cfg_next.invert_mid    = pwdata[0];
                REG_INVERT_SIDE:   cfg_next.invert_side   = pwdata[0];
                REG_MS_DECODE:     cfg_next.ms_decode     = pwdata[0];
                REG_SWAP_CHANNELS: cfg_next.swap_channels = pwdata[0];
                REG_MONO_SUM:      cfg_next.mono_sum      = pwdata[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    // Read decode.
    always_comb begin
        unique case (reg_idx)
            REG_BYPASS:        rd_bit = cfg_reg.bypass;
            REG_STEREO_MODE:   rd_bit = cfg_reg.stereo_mode;
            REG_INVERT_MONO:   rd_bit = cfg_reg.invert_mono;
            REG_INVERT_MID:    rd_bit = cfg_reg.invert_mid;
            REG_INVERT_SIDE:   rd_bit = cfg_reg.invert_side;
            REG_MS_DECODE:     rd_bit = cfg_reg.ms_decode;
            REG_SWAP_CHANNELS: rd_bit = cfg_reg.swap_channels;
            REG_MONO_SUM:      rd_bit = cfg_reg.mono_sum;
            default:           rd_bit = 1'b0;
        endcase
    end

    assign prdata = {{(PDATA_BITS-1){1'b0}}, rd_bit};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // ------------------------------------------------------------------------
    // Pipeline control: the result register frees up when it is empty or its
    // transfer completes, and the input register refills in the same cycle.
    // ------------------------------------------------------------------------
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign in_xfer = s_valid && s_ready;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            in0_reg <= s_sample_in0;
            in1_reg <= s_sample_in1;
            clr_reg <= s_clear_peaks;
        end
    end

    // Sample matrix between the two register stages.
    smpm_matrix #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_matrix (
        .cfg  (cfg_reg),
        .in0  (in0_reg),
        .in1  (in1_reg),
        .out0 (mat_out0),
        .out1 (mat_out1)
    );

    // Peak meters update as the item enters the result register.
    smpm_peak #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_peak (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && in_valid_reg),
        .clear    (clr_reg),
        .in0      (in0_reg),
        .out0     (mat_out0),
        .peak_in  (m_peak_input),
        .peak_out (m_peak_output)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            out0_reg <= mat_out0;
            out1_reg <= mat_out1;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_sample_out0 = out0_reg;
    assign m_sample_out1 = out1_reg;

endmodule

`default_nettype wire

// ===== rtl/smpm_checker.sv =====
// ============================================================================
// smpm_checker
// Port-level checks for the stereo matrix with peak meter, bound to the top.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module smpm_checker
    import smpm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input wire logic                    aclk,
    input wire logic                    aresetn,
    input wire logic                    s_ready,
    input wire logic                    m_valid,
    input wire logic                    m_ready,
    input wire logic [SAMPLE_BITS-1:0]  m_sample_out0,
    input wire logic [SAMPLE_BITS-1:0]  m_sample_out1,
    input wire logic [SAMPLE_BITS-2:0]  m_peak_input,
    input wire logic [SAMPLE_BITS-2:0]  m_peak_output
);

    localparam logic [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic [SAMPLE_BITS-1:0] neg_out0;
    logic [SAMPLE_BITS-2:0] mag_out0;

    // Saturated magnitude of the shown channel 0 result.
    assign neg_out0 = ~m_sample_out0 + 1'b1;
    assign mag_out0 = (m_sample_out0 == SMIN) ? {(SAMPLE_BITS-1){1'b1}} :
                      m_sample_out0[SAMPLE_BITS-1] ? neg_out0[SAMPLE_BITS-2:0] :
                      m_sample_out0[SAMPLE_BITS-2:0];

    // The pipeline is empty right after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A stalled result transfer keeps the whole result, peaks included.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sample_out0) &&
            $stable(m_sample_out1) && $stable(m_peak_input) && $stable(m_peak_output))
        else $error("stalled result changed");

    // The output peak always covers the channel 0 result it travels with.
    a_peak_covers: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_peak_output >= mag_out0))
        else $error("output peak below current output magnitude");

    // Whenever the result side takes data, the input side can take an item.
    a_full_rate: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while results are being taken");

endmodule

bind stereo_matrix_with_peak_meter smpm_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_smpm_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_sample_out0 (m_sample_out0),
    .m_sample_out1 (m_sample_out1),
    .m_peak_input  (m_peak_input),
    .m_peak_output (m_peak_output)
);

`default_nettype wire

// ===== tb/stereo_matrix_checker.sv =====
// ============================================================================
// stereo_matrix_checker
// Watches the register port and both sample channels of the stereo matrix.
// It keeps its own copy of the control bits and of the two peak meters,
// works out the expected output pair and peaks for every input transfer, and
// compares each result transfer against the oldest expected entry.
// ============================================================================
`timescale 1ns / 1ps

module stereo_matrix_checker
    import smpm_pkg::*;
(
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    input  wire logic                          s_ready,
    input  wire logic [SAMPLE_BITS_DEF-1:0]    s_sample_in0,
    input  wire logic [SAMPLE_BITS_DEF-1:0]    s_sample_in1,
    input  wire logic                          s_clear_peaks,
    input  wire logic                          m_valid,
    input  wire logic                          m_ready,
    input  wire logic [SAMPLE_BITS_DEF-1:0]    m_sample_out0,
    input  wire logic [SAMPLE_BITS_DEF-1:0]    m_sample_out1,
    input  wire logic [SAMPLE_BITS_DEF-2:0]    m_peak_input,
    input  wire logic [SAMPLE_BITS_DEF-2:0]    m_peak_output,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic                          pready,
    input  wire logic [PADDR_BITS-1:0]         paddr,
    input  wire logic [PDATA_BITS-1:0]         pwdata,
    output int                                 fail_count,
    output int                                 pending,
    output int                                 checked
);

    localparam int SB = SAMPLE_BITS_DEF;

    // Two spare bits hold sums and negations of full-scale samples.
    typedef logic signed [SB+1:0] wide_t;
    typedef logic signed [SB-1:0] sample_t;
    typedef logic [SB-2:0]        peak_t;

    localparam wide_t FULL_POS = wide_t'(2 ** (SB - 1) - 1);
    localparam wide_t FULL_NEG = -FULL_POS - 1;

    typedef struct {
        logic [SB-1:0] out0;
        logic [SB-1:0] out1;
        peak_t         pk_in;
        peak_t         pk_out;
    } pair_result_t;

    cfg_t         ctrl;
    peak_t        in_peak;
    peak_t        out_peak;
    pair_result_t expected_q[$];

    // Negation that maps the most negative sample onto the most positive one.
    function automatic wide_t neg_sat(wide_t x);
        return (x == FULL_NEG) ? FULL_POS : -x;
    endfunction

    // Arithmetic shift right by one rounds toward minus infinity.
    function automatic wide_t halve(wide_t x);
        return x >>> 1;
    endfunction

    // Absolute value, clipped to the peak meter range.
    function automatic peak_t magnitude(wide_t x);
        wide_t a;
        a = (x < 0) ? -x : x;
        if (a > FULL_POS)
            a = FULL_POS;
        return peak_t'(a);
    endfunction

    // Runs one sample pair through the matrix and updates both peak meters.
    function automatic pair_result_t mix_pair(sample_t in0, sample_t in1, logic clr);
        wide_t        a, b, m, s, x, y, t;
        peak_t        pi, po;
        pair_result_t r;
        a = in0;
        b = in1;
        if (!ctrl.stereo_mode) begin
            x = (!ctrl.bypass && ctrl.invert_mono) ? neg_sat(a) : a;
            y = '0;
        end else if (ctrl.bypass) begin
            x = a;
            y = b;
        end else begin
            m = ctrl.invert_mid ? neg_sat(a) : a;
            s = ctrl.invert_side ? neg_sat(b) : b;
            if (ctrl.ms_decode && ctrl.mono_sum) begin
                // The side cancels out of the decoded mono sum.
                x = halve(m);
                y = x;
            end else begin
                if (ctrl.ms_decode) begin
                    x = halve(m + s);
                    y = halve(m - s);
                end else begin
                    x = m;
                    y = s;
                end
                if (ctrl.swap_channels) begin
                    t = x;
                    x = y;
                    y = t;
                end
                if (ctrl.mono_sum) begin
                    x = halve(x + y);
                    y = x;
                end
            end
        end
        pi = magnitude(a);
        po = magnitude(x);
        if (clr) begin
            in_peak  = pi;
            out_peak = po;
        end else begin
            if (pi > in_peak)
                in_peak = pi;
            if (po > out_peak)
                out_peak = po;
        end
        r.out0   = x[SB-1:0];
        r.out1   = y[SB-1:0];
        r.pk_in  = in_peak;
        r.pk_out = out_peak;
        return r;
    endfunction

    // Track register writes, predict on input transfers, compare on result transfers.
    always @(posedge aclk) begin
        pair_result_t want;
        reg_idx_t     idx;
        if (!aresetn) begin
            ctrl       = CFG_RESET;
            in_peak    = '0;
            out_peak   = '0;
            expected_q.delete();
            fail_count = 0;
            checked    = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                idx = paddr[PADDR_BITS-1:REG_IDX_LSB];
                case (idx)
                    REG_BYPASS:        ctrl.bypass        = pwdata[0];
                    REG_STEREO_MODE:   ctrl.stereo_mode   = pwdata[0];
                    REG_INVERT_MONO:   ctrl.invert_mono   = pwdata[0];
                    REG_INVERT_MID:    ctrl.invert_mid    = pwdata[0];
                    REG_INVERT_SIDE:   ctrl.invert_side   = pwdata[0];
                    REG_MS_DECODE:     ctrl.ms_decode     = pwdata[0];
                    REG_SWAP_CHANNELS: ctrl.swap_channels = pwdata[0];
                    REG_MONO_SUM:      ctrl.mono_sum      = pwdata[0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("[%0t] result transfer with nothing expected: %h %h %h %h",
                                 $time, m_sample_out0, m_sample_out1, m_peak_input,
                                 m_peak_output);
                    fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    checked++;
                    if (m_sample_out0 !== want.out0 || m_sample_out1 !== want.out1 ||
                        m_peak_input !== want.pk_in || m_peak_output !== want.pk_out) begin
                        if (fail_count < 10) begin
                            $display("[%0t] mismatch on result %0d", $time, checked);
                            $display("    expected out0=%h out1=%h peak_in=%h peak_out=%h",
                                     want.out0, want.out1, want.pk_in, want.pk_out);
                            $display("    actual   out0=%h out1=%h peak_in=%h peak_out=%h",
                                     m_sample_out0, m_sample_out1, m_peak_input,
                                     m_peak_output);
                        end
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                expected_q.push_back(mix_pair(s_sample_in0, s_sample_in1, s_clear_peaks));
        end
        pending = expected_q.size();
    end

endmodule

// ===== tb/tb.sv =====
// ============================================================================
// tb
// Stimulus and verdict for the stereo matrix with peak meter. Walks through
// directed corner cases for each processing path, then random sample pairs
// under a series of register settings, with random gaps on both channels.
// ============================================================================
`timescale 1ns / 1ps

module tb;
    import smpm_pkg::*;

    localparam int SB          = SAMPLE_BITS_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 6;

    localparam logic [SB-1:0] FULL_POS = {1'b0, {(SB-1){1'b1}}};
    localparam logic [SB-1:0] FULL_NEG = {1'b1, {(SB-1){1'b0}}};

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic [SB-1:0]         s_sample_in0  = '0;
    logic [SB-1:0]         s_sample_in1  = '0;
    logic                  s_clear_peaks = 1'b0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic [SB-1:0]         m_sample_out0;
    logic [SB-1:0]         m_sample_out1;
    logic [SB-2:0]         m_peak_input;
    logic [SB-2:0]         m_peak_output;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [PADDR_BITS-1:0] paddr         = '0;
    logic [PDATA_BITS-1:0] pwdata        = '0;
    logic [PDATA_BITS-1:0] prdata;
    logic                  pready;

    int fail_count;
    int pending;
    int checked;
    int cycles      = 0;
    int pairs_sent  = 0;
    int settings    = 0;
    bit gaps_on     = 1'b1;

    stereo_matrix_with_peak_meter dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample_in0  (s_sample_in0),
        .s_sample_in1  (s_sample_in1),
        .s_clear_peaks (s_clear_peaks),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sample_out0 (m_sample_out0),
        .m_sample_out1 (m_sample_out1),
        .m_peak_input  (m_peak_input),
        .m_peak_output (m_peak_output),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    stereo_matrix_checker matrix_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample_in0  (s_sample_in0),
        .s_sample_in1  (s_sample_in1),
        .s_clear_peaks (s_clear_peaks),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sample_out0 (m_sample_out0),
        .m_sample_out1 (m_sample_out1),
        .m_peak_input  (m_peak_input),
        .m_peak_output (m_peak_output),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked       (checked)
    );

    // Clock with a 2 ns period.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d results outstanding.",
                     cycles, pending);
            $display("** stereo_matrix_with_peak_meter: FAILED **");
            $finish;
        end
    end

    // The result side stalls at random while gaps are enabled.
    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else if (gaps_on)
            m_ready <= ($urandom_range(99) >= 11);
        else
            m_ready <= 1'b1;
    end

    // Register write: setup, then access, then an idle pause.
    // Upper data bits are noise.
    task automatic reg_write(reg_idx_t idx, logic bit_val);
        logic [PDATA_BITS-1:0] noise;
        noise   = $urandom;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_BITS'(idx) << REG_IDX_LSB;
        pwdata  <= {noise[PDATA_BITS-1:1], bit_val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Stop sending, wait until every expected result has come back, then let
    // the pipeline settle.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Load a full register setting while the block is idle.
    task automatic load_setting(cfg_t c);
        drain();
        reg_write(REG_BYPASS,        c.bypass);
        reg_write(REG_STEREO_MODE,   c.stereo_mode);
        reg_write(REG_INVERT_MONO,   c.invert_mono);
        reg_write(REG_INVERT_MID,    c.invert_mid);
        reg_write(REG_INVERT_SIDE,   c.invert_side);
        reg_write(REG_MS_DECODE,     c.ms_decode);
        reg_write(REG_SWAP_CHANNELS, c.swap_channels);
        reg_write(REG_MONO_SUM,      c.mono_sum);
        @(posedge aclk);
        settings++;
    endtask

    // One input transfer, optionally preceded by a random gap.
    task automatic send_pair(logic [SB-1:0] in0, logic [SB-1:0] in1, logic clr);
        if (gaps_on) begin
            while ($urandom_range(99) < 11) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid       <= 1'b1;
        s_sample_in0  <= in0;
        s_sample_in1  <= in1;
        s_clear_peaks <= clr;
        do @(posedge aclk); while (!s_ready);
        pairs_sent++;
    endtask

    // Sample values weighted toward full scale and small magnitudes.
    function automatic logic [SB-1:0] pick_sample();
        case ($urandom_range(9))
            0: return FULL_NEG;
            1: return FULL_POS;
            2: return SB'($signed($urandom_range(16)) - 8);
            default: return SB'($urandom);
        endcase
    endfunction

    function automatic cfg_t random_setting();
        cfg_t c;
        c = cfg_t'(8'($urandom));
        c.bypass      = ($urandom_range(3) == 0);
        c.stereo_mode = ($urandom_range(3) != 0);
        return c;
    endfunction

    initial begin
        cfg_t c;
        int   run_len;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset setting: plain stereo pass with full-scale and clear cases.
        send_pair(FULL_NEG, FULL_POS, 1'b0);
        send_pair(FULL_POS, FULL_NEG, 1'b0);
        send_pair('0, '0, 1'b1);
        send_pair('1, SB'(1), 1'b0);

        // Mono with inversion: the most negative sample flips to the most positive.
        c = CFG_RESET;
        c.stereo_mode = 1'b0;
        c.invert_mono = 1'b1;
        load_setting(c);
        send_pair(FULL_NEG, SB'(5), 1'b0);
        send_pair(FULL_POS, SB'(-3), 1'b0);

        // Mono bypass still forces channel 1 to zero.
        c.bypass = 1'b1;
        load_setting(c);
        send_pair(FULL_NEG, FULL_POS, 1'b1);

        // Both inversions feeding the decode, including full-scale sums.
        c = CFG_RESET;
        c.invert_mid  = 1'b1;
        c.invert_side = 1'b1;
        c.ms_decode   = 1'b1;
        load_setting(c);
        send_pair(FULL_NEG, FULL_NEG, 1'b0);
        send_pair(FULL_POS, FULL_NEG, 1'b0);
        send_pair(SB'(-3), SB'(2), 1'b0);

        // Decode together with mono sum: only the mid survives.
        c = CFG_RESET;
        c.ms_decode     = 1'b1;
        c.mono_sum      = 1'b1;
        c.swap_channels = 1'b1;
        load_setting(c);
        send_pair(FULL_POS, FULL_POS, 1'b0);
        send_pair(SB'(-5), SB'(7), 1'b1);

        // Swap and mono sum without decode; odd negative sums round down.
        c.ms_decode = 1'b0;
        load_setting(c);
        send_pair(FULL_NEG, FULL_NEG, 1'b0);
        send_pair('1, SB'(-2), 1'b0);

        // Stereo bypass overrides every other control bit.
        c = '1;
        load_setting(c);
        send_pair(FULL_NEG, FULL_POS, 1'b0);
        send_pair(SB'(9), SB'(-9), 1'b1);

        // Random pairs under a series of settings; one long run without gaps.
        for (int phase = 0; phase < 16; phase++) begin
            case (phase)
                0:       c = '0;
                1:       c = '1;
                2:       c = CFG_RESET;
                default: c = random_setting();
            endcase
            load_setting(c);
            gaps_on = (phase != 5);
            run_len = (phase == 5) ? 300 : 95;
            for (int i = 0; i < run_len; i++)
                send_pair(pick_sample(), pick_sample(), ($urandom_range(9) == 0));
            gaps_on = 1'b1;
        end

        drain();

        $display("Sent %0d sample pairs and checked %0d results across %0d register settings,",
                 pairs_sent, checked, settings);
        $display("covering mono, bypass, inversion, decode, swap, mono sum and peak clears.");
        if (fail_count == 0 && pending == 0) begin
            $display("** stereo_matrix_with_peak_meter: PASSED **");
        end else begin
            $display("%0d failures, %0d results never arrived.", fail_count, pending);
            $display("** stereo_matrix_with_peak_meter: FAILED **");
        end
        $finish;
    end

endmodule
